FILE: hw/rtl/cbpm_pkg.sv
package cbpm_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PIN_BITS_DEF   = 8;
  localparam int FIU_DEF        = 16;
  localparam int RESULT_CAP     = 16;
  localparam int CFG_W          = 5;
  localparam int CAP_W          = 5;

  // request kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_UNPIN   = 3'd1;
  localparam logic [2:0] KIND_ALLOC   = 3'd2;
  localparam logic [2:0] KIND_DISPOSE = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXCEEDED   = 3'd1;
  localparam logic [2:0] ST_NOT_PINNED = 3'd2;
  localparam logic [2:0] ST_PINNED     = 3'd3;

  // disk actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_FETCH   = 3'd1;
  localparam logic [2:0] ACT_WBACK   = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_INSTALL = 3'd4;

  // pointer ops
  localparam logic [1:0] PTR_HOLD  = 2'd0;
  localparam logic [1:0] PTR_CLEAR = 2'd1;
  localparam logic [1:0] PTR_STEP  = 2'd2;
  localparam logic [1:0] PTR_HAND  = 2'd3;

  // hand ops
  localparam logic [1:0] HAND_HOLD = 2'd0;
  localparam logic [1:0] HAND_SUBN = 2'd1;
  localparam logic [1:0] HAND_PTR  = 2'd2;

  // frame ops at the pointer
  localparam logic [2:0] FOP_NONE    = 3'd0;
  localparam logic [2:0] FOP_TOUCH   = 3'd1;
  localparam logic [2:0] FOP_UNPIN   = 3'd2;
  localparam logic [2:0] FOP_INSTALL = 3'd3;
  localparam logic [2:0] FOP_INVAL   = 3'd4;
  localparam logic [2:0] FOP_CLRREF  = 3'd5;

  // pending write-back ops
  localparam logic [1:0] PEND_HOLD  = 2'd0;
  localparam logic [1:0] PEND_CLEAR = 2'd1;
  localparam logic [1:0] PEND_LOAD  = 2'd2;

  // result frame source
  localparam logic [1:0] ESRC_ZERO = 2'd0;
  localparam logic [1:0] ESRC_PTR  = 2'd1;
  localparam logic [1:0] ESRC_PEND = 2'd2;

  // result tag source
  localparam logic [1:0] ETAG_ZERO  = 2'd0;
  localparam logic [1:0] ETAG_REQ   = 2'd1;
  localparam logic [1:0] ETAG_FRAME = 2'd2;
  localparam logic [1:0] ETAG_PEND  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  file_id;
    logic [31:0] page_no;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [3:0]  frame_index;
    logic        hit;
    logic [2:0]  status;
    logic [2:0]  action;
    logic [7:0]  action_file;
    logic [31:0] action_page;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       req_load;
    logic       free_clear;
    logic       free_acc;
    logic [1:0] ptr_op;
    logic [1:0] hand_op;
    logic [2:0] frame_op;
    logic [1:0] pend_op;
    logic       emit;
    logic [1:0] e_src;
    logic       e_hit;
    logic [2:0] e_status;
    logic [2:0] e_action;
    logic [1:0] e_tag;
    logic       e_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       valid;
    logic       tag_match;
    logic       file_match;
    logic       pinned;
    logic       dirty;
    logic       ref_set;
    logic       ptr_last;
    logic       any_free;
    logic       hand_ge_n;
    logic       pend_valid;
    logic       cap_full;
  } stat_t;

endpackage

FILE: hw/rtl/cbpm_datapath.sv
module cbpm_datapath #(
  parameter int MAX_FRAMES = cbpm_pkg::MAX_FRAMES_DEF,
  parameter int PIN_BITS   = cbpm_pkg::PIN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbpm_pkg::req_t               request,
  input  logic                         cfg_we,
  input  logic [cbpm_pkg::CFG_W-1:0]   cfg_data,
  input  cbpm_pkg::cmd_t               cmd,
  output cbpm_pkg::stat_t              stat,
  output logic [$clog2(MAX_FRAMES+1)-1:0] fiu,
  output cbpm_pkg::res_t               result,
  output logic                         result_valid
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int FIU_RESET = (cbpm_pkg::FIU_DEF > MAX_FRAMES) ? MAX_FRAMES
                                                              : cbpm_pkg::FIU_DEF;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
  localparam int CAP_W_L = cbpm_pkg::CAP_W;

  logic                frame_valid [MAX_FRAMES];
  logic [7:0]          frame_file  [MAX_FRAMES];
  logic [31:0]         frame_page  [MAX_FRAMES];
  logic [PIN_BITS-1:0] frame_pin   [MAX_FRAMES];
  logic                frame_dirty [MAX_FRAMES];
  logic                frame_ref   [MAX_FRAMES];

  cbpm_pkg::req_t      req;
  logic [IW-1:0]       ptr;
  logic [IW-1:0]       hand;
  logic                any_free;
  logic                pend_valid;
  logic [IW-1:0]       pend_frame;
  logic [31:0]         pend_page;
  logic [CAP_W_L-1:0]  cap_cnt;

  logic [CW-1:0]       ptr_inc, hand_inc;
  logic [IW-1:0]       ptr_wrap, hand_wrap;
  logic                cur_valid, cur_pinned;
  logic [CW-1:0]       cfg_v;
  cbpm_pkg::res_t      res_next;

  assign ptr_inc   = CW'(ptr) + CW'(1);
  assign hand_inc  = CW'(hand) + CW'(1);
  assign ptr_wrap  = (ptr_inc == fiu) ? '0 : ptr_inc[IW-1:0];
  assign hand_wrap = (hand_inc == fiu) ? '0 : hand_inc[IW-1:0];
  assign cur_valid  = frame_valid[ptr];
  assign cur_pinned = frame_pin[ptr] != '0;

  always_comb begin
    stat.kind       = req.kind;
    stat.valid      = cur_valid;
    stat.file_match = cur_valid && frame_file[ptr] == req.file_id;
    stat.tag_match  = stat.file_match && frame_page[ptr] == req.page_no;
    stat.pinned     = cur_pinned;
    stat.dirty      = frame_dirty[ptr];
    stat.ref_set    = frame_ref[ptr];
    stat.ptr_last   = ptr_inc == fiu;
    stat.any_free   = any_free;
    stat.hand_ge_n  = CW'(hand) >= fiu;
    stat.pend_valid = pend_valid;
    stat.cap_full   = 32'(cap_cnt) >= cbpm_pkg::RESULT_CAP;
  end

  // config value clamped to 1..MAX_FRAMES
  always_comb begin
    if (cfg_data == '0) begin
      cfg_v = CW'(1);
    end else if (32'(cfg_data) > MAX_FRAMES) begin
      cfg_v = CW'(MAX_FRAMES);
    end else begin
      cfg_v = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fiu          <= CW'(FIU_RESET);
      hand         <= IW'(FIU_RESET - 1);
      ptr          <= '0;
      any_free     <= 1'b0;
      pend_valid   <= 1'b0;
      cap_cnt      <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_valid[i] <= 1'b0;
        frame_pin[i]   <= '0;
        frame_dirty[i] <= 1'b0;
        frame_ref[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        fiu <= cfg_v;
      end
      if (cmd.free_clear) begin
        any_free <= 1'b0;
      end else if (cmd.free_acc) begin
        any_free <= any_free | !cur_valid | !cur_pinned;
      end
      case (cmd.ptr_op)
        cbpm_pkg::PTR_CLEAR: ptr <= '0;
        cbpm_pkg::PTR_STEP:  ptr <= ptr_wrap;
        cbpm_pkg::PTR_HAND:  ptr <= hand_wrap;
        default: ;
      endcase
      case (cmd.hand_op)
        cbpm_pkg::HAND_SUBN: hand <= IW'(CW'(hand) - fiu);
        cbpm_pkg::HAND_PTR:  hand <= ptr;
        default: ;
      endcase
      case (cmd.pend_op)
        cbpm_pkg::PEND_CLEAR: begin
          pend_valid <= 1'b0;
          cap_cnt    <= '0;
        end
        cbpm_pkg::PEND_LOAD: begin
          pend_valid <= 1'b1;
          cap_cnt    <= cap_cnt + CAP_W_L'(1);
        end
        default: ;
      endcase
      case (cmd.frame_op)
        cbpm_pkg::FOP_TOUCH: begin
          frame_ref[ptr] <= 1'b1;
          if (frame_pin[ptr] != PIN_MAX) begin
            frame_pin[ptr] <= frame_pin[ptr] + PIN_BITS'(1);
          end
        end
        cbpm_pkg::FOP_UNPIN: begin
          frame_pin[ptr] <= frame_pin[ptr] - PIN_BITS'(1);
          if (req.mark_dirty) begin
            frame_dirty[ptr] <= 1'b1;
          end
        end
        cbpm_pkg::FOP_INSTALL: begin
          frame_valid[ptr] <= 1'b1;
          frame_pin[ptr]   <= PIN_BITS'(1);
          frame_dirty[ptr] <= 1'b0;
          frame_ref[ptr]   <= 1'b1;
        end
        cbpm_pkg::FOP_INVAL: begin
          frame_valid[ptr] <= 1'b0;
          frame_dirty[ptr] <= 1'b0;
          frame_ref[ptr]   <= 1'b0;
        end
        cbpm_pkg::FOP_CLRREF: frame_ref[ptr] <= 1'b0;
        default: ;
      endcase
      result_valid <= cmd.emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= request;
    end
    if (cmd.frame_op == cbpm_pkg::FOP_INSTALL) begin
      frame_file[ptr] <= req.file_id;
      frame_page[ptr] <= req.page_no;
    end
    if (cmd.pend_op == cbpm_pkg::PEND_LOAD) begin
      pend_frame <= ptr;
      pend_page  <= frame_page[ptr];
    end
    if (cmd.emit) begin
      result <= res_next;
    end
  end

  always_comb begin
    res_next.hit    = cmd.e_hit;
    res_next.status = cmd.e_status;
    res_next.action = cmd.e_action;
    res_next.last   = cmd.e_last;
    case (cmd.e_src)
      cbpm_pkg::ESRC_PTR:  res_next.frame_index = 4'(ptr);
      cbpm_pkg::ESRC_PEND: res_next.frame_index = 4'(pend_frame);
      default:             res_next.frame_index = '0;
    endcase
    case (cmd.e_tag)
      cbpm_pkg::ETAG_REQ: begin
        res_next.action_file = req.file_id;
        res_next.action_page = req.page_no;
      end
      cbpm_pkg::ETAG_FRAME: begin
        res_next.action_file = frame_file[ptr];
        res_next.action_page = frame_page[ptr];
      end
      cbpm_pkg::ETAG_PEND: begin
        res_next.action_file = req.file_id;
        res_next.action_page = pend_page;
      end
      default: begin
        res_next.action_file = '0;
        res_next.action_page = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/cbpm_ctrl.sv
module cbpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2:0]      start_kind,
  input  cbpm_pkg::stat_t stat,
  output cbpm_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_HIT   = 4'd2;
  localparam logic [3:0] S_MISS  = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_VICT  = 4'd6;
  localparam logic [3:0] S_INST  = 4'd7;
  localparam logic [3:0] S_FLCHK = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;
  localparam logic [3:0] S_FLEND = 4'd10;

  logic [3:0] state, state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.req_load   = 1'b1;
          cmd.free_clear = 1'b1;
          cmd.ptr_op     = cbpm_pkg::PTR_CLEAR;
          if (start_kind == cbpm_pkg::KIND_FLUSH) begin
            state_next = S_FLCHK;
          end else if (start_kind < cbpm_pkg::KIND_FLUSH) begin
            state_next = S_SCAN;
          end
        end
      end
      // tag search, one frame a cycle, also noting any free frame
      S_SCAN: begin
        cmd.free_acc = 1'b1;
        if (stat.tag_match) begin
          state_next = S_HIT;
        end else if (stat.ptr_last) begin
          state_next = S_MISS;
        end else begin
          cmd.ptr_op = cbpm_pkg::PTR_STEP;
        end
      end
      S_HIT: begin
        cmd.emit   = 1'b1;
        cmd.e_src  = cbpm_pkg::ESRC_PTR;
        cmd.e_hit  = 1'b1;
        cmd.e_last = 1'b1;
        state_next = S_IDLE;
        case (stat.kind)
          cbpm_pkg::KIND_READ: cmd.frame_op = cbpm_pkg::FOP_TOUCH;
          cbpm_pkg::KIND_UNPIN: begin
            if (stat.pinned) begin
              cmd.frame_op = cbpm_pkg::FOP_UNPIN;
            end else begin
              cmd.e_status = cbpm_pkg::ST_NOT_PINNED;
            end
          end
          cbpm_pkg::KIND_ALLOC: begin
            if (stat.pinned) begin
              cmd.e_status = cbpm_pkg::ST_PINNED;
            end else begin
              cmd.frame_op = cbpm_pkg::FOP_INSTALL;
              cmd.e_action = cbpm_pkg::ACT_INSTALL;
              cmd.e_tag    = cbpm_pkg::ETAG_REQ;
            end
          end
          default: begin
            if (stat.pinned) begin
              cmd.e_status = cbpm_pkg::ST_PINNED;
            end else begin
              cmd.frame_op = cbpm_pkg::FOP_INVAL;
              cmd.e_action = cbpm_pkg::ACT_DELETE;
              cmd.e_tag    = cbpm_pkg::ETAG_REQ;
            end
          end
        endcase
      end
      S_MISS: begin
        case (stat.kind)
          cbpm_pkg::KIND_UNPIN: begin
            cmd.emit   = 1'b1;
            cmd.e_last = 1'b1;
            state_next = S_IDLE;
          end
          cbpm_pkg::KIND_DISPOSE: begin
            cmd.emit     = 1'b1;
            cmd.e_last   = 1'b1;
            cmd.e_action = cbpm_pkg::ACT_DELETE;
            cmd.e_tag    = cbpm_pkg::ETAG_REQ;
            state_next   = S_IDLE;
          end
          default: begin
            if (stat.any_free) begin
              state_next = S_NORM;
            end else begin
              cmd.emit     = 1'b1;
              cmd.e_last   = 1'b1;
              cmd.e_status = cbpm_pkg::ST_EXCEEDED;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      // bring the hand into range after a frame-count change
      S_NORM: begin
        if (stat.hand_ge_n) begin
          cmd.hand_op = cbpm_pkg::HAND_SUBN;
        end else begin
          cmd.ptr_op = cbpm_pkg::PTR_HAND;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.hand_op = cbpm_pkg::HAND_PTR;
        if (!stat.valid) begin
          state_next = S_VICT;
        end else if (stat.ref_set) begin
          cmd.frame_op = cbpm_pkg::FOP_CLRREF;
          cmd.ptr_op   = cbpm_pkg::PTR_STEP;
        end else if (stat.pinned) begin
          cmd.ptr_op = cbpm_pkg::PTR_STEP;
        end else begin
          state_next = S_VICT;
        end
      end
      S_VICT: begin
        if (stat.valid && stat.dirty) begin
          cmd.emit     = 1'b1;
          cmd.e_src    = cbpm_pkg::ESRC_PTR;
          cmd.e_action = cbpm_pkg::ACT_WBACK;
          cmd.e_tag    = cbpm_pkg::ETAG_FRAME;
        end
        state_next = S_INST;
      end
      S_INST: begin
        cmd.frame_op = cbpm_pkg::FOP_INSTALL;
        cmd.emit     = 1'b1;
        cmd.e_src    = cbpm_pkg::ESRC_PTR;
        cmd.e_tag    = cbpm_pkg::ETAG_REQ;
        cmd.e_last   = 1'b1;
        cmd.e_action = (stat.kind == cbpm_pkg::KIND_READ) ? cbpm_pkg::ACT_FETCH
                                                          : cbpm_pkg::ACT_INSTALL;
        state_next   = S_IDLE;
      end
      S_FLCHK: begin
        if (stat.file_match && stat.pinned) begin
          cmd.emit     = 1'b1;
          cmd.e_src    = cbpm_pkg::ESRC_PTR;
          cmd.e_hit    = 1'b1;
          cmd.e_status = cbpm_pkg::ST_PINNED;
          cmd.e_last   = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.ptr_last) begin
          cmd.ptr_op  = cbpm_pkg::PTR_CLEAR;
          cmd.pend_op = cbpm_pkg::PEND_CLEAR;
          state_next  = S_FLUSH;
        end else begin
          cmd.ptr_op = cbpm_pkg::PTR_STEP;
        end
      end
      // one write-back is held back until the next one shows whether it is last
      S_FLUSH: begin
        if (stat.file_match) begin
          if (!stat.dirty) begin
            cmd.frame_op = cbpm_pkg::FOP_INVAL;
          end else if (!stat.cap_full) begin
            cmd.frame_op = cbpm_pkg::FOP_INVAL;
            cmd.pend_op  = cbpm_pkg::PEND_LOAD;
            if (stat.pend_valid) begin
              cmd.emit     = 1'b1;
              cmd.e_src    = cbpm_pkg::ESRC_PEND;
              cmd.e_hit    = 1'b1;
              cmd.e_action = cbpm_pkg::ACT_WBACK;
              cmd.e_tag    = cbpm_pkg::ETAG_PEND;
            end
          end
        end
        if (stat.ptr_last) begin
          state_next = S_FLEND;
        end else begin
          cmd.ptr_op = cbpm_pkg::PTR_STEP;
        end
      end
      S_FLEND: begin
        cmd.emit   = 1'b1;
        cmd.e_last = 1'b1;
        if (stat.pend_valid) begin
          cmd.e_src    = cbpm_pkg::ESRC_PEND;
          cmd.e_hit    = 1'b1;
          cmd.e_action = cbpm_pkg::ACT_WBACK;
          cmd.e_tag    = cbpm_pkg::ETAG_PEND;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/clock_buffer_pool_manager_core.sv
// a flush walks the n active frames twice (pin check, then flush); a miss walks them
// once for the tag scan, then brings the hand into range and runs the clock sweep
// throughput: one item at a time, set by the single frame-table port walked a frame a cycle
// results come at most one per cycle on result_valid; the receiver cannot stall
// reset (synchronous, active high) empties all frames and sets 16 active frames, capped at MAX_FRAMES
module clock_buffer_pool_manager_core #(
  parameter int MAX_FRAMES = cbpm_pkg::MAX_FRAMES_DEF,
  parameter int PIN_BITS   = cbpm_pkg::PIN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  // request channel
  input  logic            start,
  output logic            busy,
  input  cbpm_pkg::req_t  request,
  // result channel
  output logic            result_valid,
  output cbpm_pkg::res_t  result,
  // register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cbpm_pkg::cmd_t  cmd;
  cbpm_pkg::stat_t stat;
  logic [$clog2(MAX_FRAMES+1)-1:0] fiu;
  logic cfg_we;

  // the only register, frames_in_use, answers at byte addresses 0 to 3 (paddr[2] low)
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : 32'(fiu);

  // state machine: sequences scans, clock sweep and result emission
  cbpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_kind (request.kind),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // frame table, clock hand, walk pointer and result register
  cbpm_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PIN_BITS   (PIN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata[cbpm_pkg::CFG_W-1:0]),
    .cmd          (cmd),
    .stat         (stat),
    .fiu          (fiu),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

FILE: bench/clock_buffer_pool_manager_core_tb.sv
`timescale 1ns / 1ps

module clock_buffer_pool_manager_core_tb;

  localparam int NF      = 16;
  localparam int PIN_TOP = 255;
  // drain margin after the last result: a full sweep plus a flush walk
  localparam int SETTLE  = 3 * NF + 12;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  cbpm_pkg::req_t request = '0;
  logic           result_valid;
  cbpm_pkg::res_t result;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  clock_buffer_pool_manager_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow frame table
  logic        fv   [NF];
  logic [7:0]  ffile[NF];
  logic [31:0] fpage[NF];
  int          fpin [NF];
  logic        fdirty[NF];
  logic        fref [NF];
  int          hand;
  int          active_n;

  cbpm_pkg::res_t pending_results[$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  bit   idle_on = 1'b1;

  // small tag pools so hits and pinned frames are frequent
  logic [7:0]  file_pool[4] = '{8'h00, 8'h5a, 8'hff, 8'h81};
  logic [31:0] page_pool[6];

  function automatic cbpm_pkg::res_t mk(int fr, bit h, logic [2:0] st, logic [2:0] act,
                                        logic [7:0] af, logic [31:0] ap, bit l);
    cbpm_pkg::res_t r;
    r.frame_index = fr[3:0];
    r.hit = h;
    r.status = st;
    r.action = act;
    r.action_file = af;
    r.action_page = ap;
    r.last = l;
    return r;
  endfunction

  function automatic int lookup(logic [7:0] f, logic [31:0] p);
    for (int i = 0; i < active_n; i++)
      if (fv[i] && ffile[i] == f && fpage[i] == p) return i;
    return -1;
  endfunction

  // clock sweep: advance the hand, then look
  function automatic int sweep_victim();
    bit any;
    int h;
    any = 1'b0;
    for (int i = 0; i < active_n; i++)
      if (!fv[i] || fpin[i] == 0) any = 1'b1;
    if (!any) return -1;
    for (int s = 0; s < 3 * NF; s++) begin
      h = (hand % active_n + 1) % active_n;
      hand = h;
      if (!fv[h]) return h;
      if (fref[h]) begin
        fref[h] = 1'b0;
        continue;
      end
      if (fpin[h] != 0) continue;
      return h;
    end
    return -1;
  endfunction

  function automatic void place(int f, logic [7:0] fl, logic [31:0] pg);
    fv[f] = 1'b1;
    ffile[f] = fl;
    fpage[f] = pg;
    fpin[f] = 1;
    fdirty[f] = 1'b0;
    fref[f] = 1'b1;
  endfunction

  function automatic void miss_fill(logic [7:0] fl, logic [31:0] pg, logic [2:0] act);
    int f;
    f = sweep_victim();
    if (f < 0) begin
      pending_results.push_back(mk(0, 0, cbpm_pkg::ST_EXCEEDED, cbpm_pkg::ACT_NONE,
                                   0, 0, 1));
      return;
    end
    if (fv[f] && fdirty[f])
      pending_results.push_back(mk(f, 0, cbpm_pkg::ST_OK, cbpm_pkg::ACT_WBACK,
                                   ffile[f], fpage[f], 0));
    place(f, fl, pg);
    pending_results.push_back(mk(f, 0, cbpm_pkg::ST_OK, act, fl, pg, 1));
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(cbpm_pkg::req_t q);
    int f;
    int k;
    f = lookup(q.file_id, q.page_no);
    case (q.kind)
      cbpm_pkg::KIND_READ: begin
        if (f < 0) miss_fill(q.file_id, q.page_no, cbpm_pkg::ACT_FETCH);
        else begin
          fref[f] = 1'b1;
          if (fpin[f] < PIN_TOP) fpin[f]++;
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_OK, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        end
      end
      cbpm_pkg::KIND_UNPIN: begin
        if (f < 0)
          pending_results.push_back(mk(0, 0, cbpm_pkg::ST_OK, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        else if (fpin[f] == 0)
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_NOT_PINNED, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        else begin
          fpin[f]--;
          if (q.mark_dirty) fdirty[f] = 1'b1;
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_OK, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        end
      end
      cbpm_pkg::KIND_ALLOC: begin
        if (f < 0) miss_fill(q.file_id, q.page_no, cbpm_pkg::ACT_INSTALL);
        else if (fpin[f] != 0)
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_PINNED, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        else begin
          place(f, q.file_id, q.page_no);
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_OK, cbpm_pkg::ACT_INSTALL,
                                       q.file_id, q.page_no, 1));
        end
      end
      cbpm_pkg::KIND_DISPOSE: begin
        if (f < 0)
          pending_results.push_back(mk(0, 0, cbpm_pkg::ST_OK, cbpm_pkg::ACT_DELETE,
                                       q.file_id, q.page_no, 1));
        else if (fpin[f] != 0)
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_PINNED, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        else begin
          fv[f] = 1'b0;
          fdirty[f] = 1'b0;
          fref[f] = 1'b0;
          pending_results.push_back(mk(f, 1, cbpm_pkg::ST_OK, cbpm_pkg::ACT_DELETE,
                                       q.file_id, q.page_no, 1));
        end
      end
      cbpm_pkg::KIND_FLUSH: begin
        // any pinned page of the file blocks the whole flush
        for (int i = 0; i < active_n; i++)
          if (fv[i] && ffile[i] == q.file_id && fpin[i] != 0) begin
            pending_results.push_back(mk(i, 1, cbpm_pkg::ST_PINNED, cbpm_pkg::ACT_NONE,
                                         0, 0, 1));
            return;
          end
        k = 0;
        for (int i = 0; i < active_n; i++) begin
          if (!fv[i] || ffile[i] != q.file_id) continue;
          if (fdirty[i]) begin
            if (k >= cbpm_pkg::RESULT_CAP) continue;
            pending_results.push_back(mk(i, 1, cbpm_pkg::ST_OK, cbpm_pkg::ACT_WBACK,
                                         q.file_id, fpage[i], 0));
            k++;
          end
          fv[i] = 1'b0;
          fdirty[i] = 1'b0;
          fref[i] = 1'b0;
        end
        if (k == 0)
          pending_results.push_back(mk(0, 0, cbpm_pkg::ST_OK, cbpm_pkg::ACT_NONE,
                                       0, 0, 1));
        else pending_results[pending_results.size() - 1].last = 1'b1;
      end
      default: ; // unknown kind: ignored
    endcase
  endfunction

  // result checker: the receiver always takes the result
  always @(posedge clk) begin
    cbpm_pkg::res_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: actual %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result.frame_index !== want.frame_index || result.hit !== want.hit ||
            result.status !== want.status || result.action !== want.action ||
            result.action_file !== want.action_file ||
            result.action_page !== want.action_page || result.last !== want.last) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, want, result);
        end
      end
    end
  end

  // send one item; all tasks run right after a rising edge
  task automatic send_request(logic [2:0] kd, logic [7:0] fl, logic [31:0] pg, bit md);
    cbpm_pkg::req_t q;
    q.kind = kd;
    q.file_id = fl;
    q.page_no = pg;
    q.mark_dirty = md;
    request <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // accepted at this edge
    predict_request(q);
    items_sent++;
    if (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every expected result plus the SETTLE drain margin
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frames(logic [4:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (v < 1) active_n = 1;
    else if (v > NF) active_n = NF;
    else active_n = v;
    @(posedge clk);
  endtask

  // every kind and the special cases, with extreme tags
  task automatic test_directed();
    send_request(cbpm_pkg::KIND_READ, 8'h00, 32'h0, 0);          // miss, fetch
    send_request(cbpm_pkg::KIND_READ, 8'h00, 32'h0, 0);          // hit
    send_request(cbpm_pkg::KIND_UNPIN, 8'h00, 32'h0, 1);         // dirty
    send_request(cbpm_pkg::KIND_UNPIN, 8'h00, 32'h0, 0);
    send_request(cbpm_pkg::KIND_UNPIN, 8'h00, 32'h0, 0);         // not pinned
    send_request(cbpm_pkg::KIND_UNPIN, 8'h33, 32'h1234, 1);      // not resident
    send_request(cbpm_pkg::KIND_ALLOC, 8'h00, 32'h0, 0);         // reinstall in place
    send_request(cbpm_pkg::KIND_ALLOC, 8'h00, 32'h0, 0);         // pinned
    send_request(cbpm_pkg::KIND_DISPOSE, 8'h00, 32'h0, 0);       // pinned
    send_request(cbpm_pkg::KIND_UNPIN, 8'h00, 32'h0, 0);
    send_request(cbpm_pkg::KIND_DISPOSE, 8'h00, 32'h0, 0);       // resident delete
    send_request(cbpm_pkg::KIND_DISPOSE, 8'h00, 32'h0, 1);       // not resident delete
    send_request(cbpm_pkg::KIND_READ, 8'hff, 32'hffff_ffff, 1);
    send_request(cbpm_pkg::KIND_FLUSH, 8'hff, 32'h0, 0);         // blocked by pin
    send_request(cbpm_pkg::KIND_UNPIN, 8'hff, 32'hffff_ffff, 1);
    send_request(cbpm_pkg::KIND_READ, 8'hff, 32'h8000_0001, 0);
    send_request(cbpm_pkg::KIND_UNPIN, 8'hff, 32'h8000_0001, 1);
    send_request(cbpm_pkg::KIND_FLUSH, 8'hff, 32'hffff_ffff, 1); // two write-backs
    send_request(cbpm_pkg::KIND_FLUSH, 8'h12, 32'h0, 0);         // nothing resident
    send_request(3'd5, 8'haa, 32'h5555_aaaa, 1);                 // unknown kinds
    send_request(3'd6, 8'h55, 32'haaaa_5555, 0);
    send_request(3'd7, 8'hff, 32'hffff_ffff, 1);
    send_request(cbpm_pkg::KIND_ALLOC, 8'h7e, 32'h0000_ffff, 0); // new page
  endtask

  // one frame: full buffer, dirty victim write-back
  task automatic test_single_frame();
    write_frames(5'd1);
    send_request(cbpm_pkg::KIND_READ, 8'h01, 32'h10, 0);
    send_request(cbpm_pkg::KIND_READ, 8'h01, 32'h11, 0);          // buffer exceeded
    send_request(cbpm_pkg::KIND_ALLOC, 8'h01, 32'h12, 0);         // buffer exceeded
    send_request(cbpm_pkg::KIND_UNPIN, 8'h01, 32'h10, 1);
    send_request(cbpm_pkg::KIND_READ, 8'h01, 32'h11, 0);          // write-back then fetch
  endtask

  // allocate one page of one file per frame, dirty them all, then flush that file
  task automatic test_full_flush();
    write_frames(5'd16);
    send_request(cbpm_pkg::KIND_FLUSH, 8'h01, 32'h0, 0);
    for (int i = 0; i < NF; i++)
      send_request(cbpm_pkg::KIND_ALLOC, 8'h07, 32'h100 + i, 0);
    for (int i = 0; i < NF; i++)
      send_request(cbpm_pkg::KIND_UNPIN, 8'h07, 32'h100 + i, 1);
    send_request(cbpm_pkg::KIND_FLUSH, 8'h07, 32'h0, 0);
  endtask

  task automatic random_burst(int count);
    int r;
    logic [2:0]  kd;
    logic [7:0]  fl;
    logic [31:0] pg;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 35) kd = cbpm_pkg::KIND_READ;
      else if (r < 62) kd = cbpm_pkg::KIND_UNPIN;
      else if (r < 76) kd = cbpm_pkg::KIND_ALLOC;
      else if (r < 88) kd = cbpm_pkg::KIND_DISPOSE;
      else if (r < 97) kd = cbpm_pkg::KIND_FLUSH;
      else kd = 3'($urandom_range(5, 7));
      fl = ($urandom_range(9) == 0) ? 8'($urandom) : file_pool[$urandom_range(3)];
      pg = ($urandom_range(9) == 0) ? $urandom : page_pool[$urandom_range(5)];
      send_request(kd, fl, pg, 1'($urandom));
    end
  endtask

  // random phases over several frame counts, extremes and out-of-range values included
  task automatic test_random();
    page_pool[0] = 32'h0;
    page_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 6; i++) page_pool[i] = $urandom;
    write_frames(5'd16);
    random_burst(40);
    // hold off until everything has come back, then resume
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    idle_on = 1'b0;
    random_burst(30);                                // no idling
    idle_on = 1'b1;
    write_frames(5'd2);
    random_burst(30);
    write_frames(5'd1);
    random_burst(20);
    write_frames(5'd4);
    random_burst(30);
    write_frames(5'd0);
    random_burst(10);
    write_frames(5'd31);
    random_burst(25);
    write_frames(5'd17);
    random_burst(15);
  endtask

  initial begin
    for (int i = 0; i < NF; i++) begin
      fv[i] = 1'b0;
      ffile[i] = '0;
      fpage[i] = '0;
      fpin[i] = 0;
      fdirty[i] = 1'b0;
      fref[i] = 1'b0;
    end
    active_n = NF;
    hand = NF - 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_single_frame();
    test_full_flush();
    test_random();
    drain();
    $display("covered %0d items and %0d results: all kinds, misses, full buffer,",
             items_sent, results_seen);
    $display("flushes, pin counting, and frame counts from 1 to 16 and out of range");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cbpm_pkg.sv
hw/rtl/cbpm_datapath.sv
hw/rtl/cbpm_ctrl.sv
hw/rtl/clock_buffer_pool_manager_core.sv
bench/clock_buffer_pool_manager_core_tb.sv
